>>> design/pvp_pkg.sv
// Shared types and constants for the planar video store and palette unit.
// Holds field widths, access codes and the control bundles between modules.
// No dependencies.
package pvp_pkg;

    localparam int FUNC_W    = 3;
    localparam int OFF_W     = 18;
    localparam int DATA_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int COMP_W    = 6;
    localparam int ENTRY_W   = 3 * COMP_W;
    localparam int PLANES    = 4;
    localparam int ROW_DATA_W = PLANES * BYTE_W;

    localparam int PLANE_BYTES_DEF     = 65536;
    localparam int PALETTE_ENTRIES_DEF = 256;

    // Access codes carried by func. Code 7 is unused and does nothing.
    typedef enum logic [FUNC_W-1:0] {
        FN_PLANE_WR = 3'd0,
        FN_BYTE_RD  = 3'd1,
        FN_MASK_WR  = 3'd2,
        FN_VALUE_WR = 3'd3,
        FN_PAL_IDX  = 3'd4,
        FN_PAL_COMP = 3'd5,
        FN_PIX_FETCH = 3'd6
    } func_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } store_ctl_t;

    typedef struct packed {
        logic idx_wr;
        logic comp_wr;
        logic rd_en;
    } pal_ctl_t;

endpackage

>>> design/pvp_addr_div.sv
// Splits a byte address into plane row and plane number by a constant divide.
// Two register stages: reciprocal multiply, then back-multiply; the
// one-step correction is combinational on the second stage. Uses pvp_pkg.
module pvp_addr_div #(
    parameter int PLANE_BYTES = pvp_pkg::PLANE_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          start,
    input  logic [pvp_pkg::OFF_W-1:0]     offset,
    output logic [$clog2(PLANE_BYTES)-1:0] row,
    output logic [1:0]                    plane
);
    import pvp_pkg::*;

    localparam int ROW_W = $clog2(PLANE_BYTES);
    localparam int DIV_W = ROW_W + 1;
    localparam int RCP_W = OFF_W + 1;
    localparam int PRD_W = OFF_W + RCP_W;
    localparam int CMP_W = (OFF_W > DIV_W) ? OFF_W : DIV_W;
    localparam int MUL_W = RCP_W + CMP_W;
    localparam logic [RCP_W-1:0] RECIP   = RCP_W'((2 ** OFF_W) / PLANE_BYTES);
    localparam logic [CMP_W-1:0] DIVISOR = CMP_W'(PLANE_BYTES);

    logic [OFF_W-1:0] x_reg;
    logic [PRD_W-1:0] prod_reg;
    logic [OFF_W-1:0] x2_reg;
    logic [RCP_W-1:0] qest_reg;
    logic [OFF_W-1:0] qd_reg;

    logic [RCP_W-1:0] qest;
    logic [OFF_W-1:0] rem_est;
    logic [CMP_W-1:0] rem_ext;
    logic [CMP_W-1:0] rem_fix;
    logic [RCP_W-1:0] quo_fix;

    assign qest = prod_reg[OFF_W +: RCP_W];

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= offset;
            prod_reg <= PRD_W'(offset) * PRD_W'(RECIP);
        end
        x2_reg   <= x_reg;
        qest_reg <= qest;
        qd_reg   <= OFF_W'(MUL_W'(qest) * MUL_W'(DIVISOR));
    end

    // The estimate is never above the true quotient and at most one below it.
    always_comb
    begin
        rem_est = x2_reg - qd_reg;
        rem_ext = CMP_W'(rem_est);
        if (rem_ext >= DIVISOR)
        begin
            rem_fix = rem_ext - DIVISOR;
            quo_fix = qest_reg + RCP_W'(1);
        end
        else
        begin
            rem_fix = rem_ext;
            quo_fix = qest_reg;
        end
    end

    assign row   = ROW_W'(rem_fix);
    assign plane = quo_fix[1:0];

endmodule

>>> design/pvp_plane_store.sv
// Video store: one row per plane offset, holding the byte of all four planes.
// Synchronous memory with registered read and a clearing pass after reset.
// Uses pvp_pkg.
module pvp_plane_store #(
    parameter int PLANE_BYTES = pvp_pkg::PLANE_BYTES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pvp_pkg::store_ctl_t               ctl,
    input  logic [$clog2(PLANE_BYTES)-1:0]    row,
    input  logic [pvp_pkg::ROW_DATA_W-1:0]    wdata,
    output logic [pvp_pkg::ROW_DATA_W-1:0]    rdata,
    output logic                              clearing
);
    import pvp_pkg::*;

    localparam int ROW_W = $clog2(PLANE_BYTES);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(PLANE_BYTES - 1);

    logic [ROW_DATA_W-1:0] mem [PLANE_BYTES];
    logic [ROW_DATA_W-1:0] rdata_reg;
    logic                  clr_active_reg;
    logic                  clr_active_next;
    logic [ROW_W-1:0]      clr_row_reg;
    logic [ROW_W-1:0]      clr_row_next;

    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_row_next    = clr_row_reg;
        if (clr_active_reg)
        begin
            clr_row_next = clr_row_reg + ROW_W'(1);
            if (clr_row_reg == LAST_ROW)
            begin
                clr_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_row_reg    <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_row_reg    <= clr_row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_active_reg)
        begin
            mem[clr_row_reg] <= '0;
        end
        else if (ctl.wr_en)
        begin
            mem[row] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[row];
        end
    end

    assign rdata    = rdata_reg;
    assign clearing = clr_active_reg;

endmodule

>>> design/pvp_palette.sv
// Color table with index and component staging, plus per-entry valid bits
// so that a never-written entry reads as zero after reset. Uses pvp_pkg.
module pvp_palette #(
    parameter int PALETTE_ENTRIES = pvp_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pvp_pkg::pal_ctl_t              ctl,
    input  logic [pvp_pkg::BYTE_W-1:0]     data_byte,
    input  logic [pvp_pkg::BYTE_W-1:0]     pix,
    output logic [pvp_pkg::ENTRY_W-1:0]    entry
);
    import pvp_pkg::*;

    localparam int PAL_AW  = $clog2(PALETTE_ENTRIES);
    localparam int FOLD_N  = 2 ** BYTE_W;

    logic [ENTRY_W-1:0]         pal_mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] valid_reg;
    logic [PALETTE_ENTRIES-1:0] valid_next;
    logic [ENTRY_W-1:0]         rd_data_reg;
    logic                       rd_valid_reg;
    logic [BYTE_W-1:0]          color_index_reg;
    logic [BYTE_W-1:0]          color_index_next;
    logic [1:0]                 comp_count_reg;
    logic [1:0]                 comp_count_next;
    logic [COMP_W-1:0]          staged_reg [2];
    logic [PAL_AW-1:0]          fold [FOLD_N];
    logic [COMP_W-1:0]          comp;
    logic                       commit;
    logic [PAL_AW-1:0]          wr_addr;
    logic [PAL_AW-1:0]          rd_addr;

    // Byte value folded onto the table size, worked out at elaboration.
    for (genvar g = 0; g < FOLD_N; g++)
    begin : g_fold
        assign fold[g] = PAL_AW'(g % PALETTE_ENTRIES);
    end

    assign comp    = data_byte[COMP_W-1:0];
    assign commit  = ctl.comp_wr && (comp_count_reg == 2'd2);
    assign wr_addr = fold[color_index_reg];
    assign rd_addr = fold[pix];

    always_comb
    begin
        color_index_next = color_index_reg;
        comp_count_next  = comp_count_reg;
        valid_next       = valid_reg;
        if (ctl.idx_wr)
        begin
            color_index_next = data_byte;
        end
        else if (commit)
        begin
            color_index_next    = color_index_reg + BYTE_W'(1);
            comp_count_next     = 2'd0;
            valid_next[wr_addr] = 1'b1;
        end
        else if (ctl.comp_wr)
        begin
            comp_count_next = comp_count_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_index_reg <= '0;
            comp_count_reg  <= '0;
            valid_reg       <= '0;
            rd_valid_reg    <= 1'b0;
        end
        else
        begin
            color_index_reg <= color_index_next;
            comp_count_reg  <= comp_count_next;
            valid_reg       <= valid_next;
            if (ctl.rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.comp_wr && !commit)
        begin
            staged_reg[comp_count_reg[0]] <= comp;
        end
        if (commit)
        begin
            pal_mem[wr_addr] <= {staged_reg[0], staged_reg[1], comp};
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= pal_mem[rd_addr];
        end
    end

    assign entry = rd_valid_reg ? rd_data_reg : '0;

endmodule

>>> design/planar_vram_palette_unit.sv
// Top level of the planar video store and palette unit: access sequencer,
// mask and value registers and the output register. Instantiates
// pvp_addr_div, pvp_plane_store and pvp_palette; uses pvp_pkg.
//
//   Channel  Valid      Stall      Payload
//   input    in_valid   in_stall   func, offset, data, upper_lane_only
//   output   out_valid  out_stall  read_data, red, green, blue
//
// One word is in work at a time. The reciprocal multiply of the address
// division is registered at acceptance, then come the back-multiply, the
// store read, the modify and write-back step, a palette read for a pixel
// fetch, and the load of the output register. The next word can be taken
// the cycle after that load.
// After reset the video store is cleared one row a cycle, and in_stall
// stays high during that pass.
// A result held by out_stall does not block acceptance of the next word,
// which runs up to the output load and waits there.
module planar_vram_palette_unit #(
    parameter int PLANE_BYTES     = pvp_pkg::PLANE_BYTES_DEF,
    parameter int PALETTE_ENTRIES = pvp_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [pvp_pkg::FUNC_W-1:0]    func,
    input  logic [pvp_pkg::OFF_W-1:0]     offset,
    input  logic [pvp_pkg::DATA_W-1:0]    data,
    input  logic                          upper_lane_only,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [pvp_pkg::BYTE_W-1:0]    read_data,
    output logic [pvp_pkg::BYTE_W-1:0]    red,
    output logic [pvp_pkg::BYTE_W-1:0]    green,
    output logic [pvp_pkg::BYTE_W-1:0]    blue
);
    import pvp_pkg::*;

    localparam int ROW_W = $clog2(PLANE_BYTES);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_DIV  = 6'b000010,
        ST_RD   = 6'b000100,
        ST_MOD  = 6'b001000,
        ST_PAL  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [FUNC_W-1:0]   func_reg;
    logic [DATA_W-1:0]   data_reg;
    logic                upper_reg;
    logic [BYTE_W-1:0]   mask_reg;
    logic [BYTE_W-1:0]   mask_next;
    logic [BYTE_W-1:0]   value_reg;
    logic [BYTE_W-1:0]   value_next;

    // Result of the word in work, waiting for the output register.
    logic [BYTE_W-1:0]   res_read_reg;
    logic [BYTE_W-1:0]   res_read_next;
    logic [BYTE_W-1:0]   res_red_reg;
    logic [BYTE_W-1:0]   res_red_next;
    logic [BYTE_W-1:0]   res_green_reg;
    logic [BYTE_W-1:0]   res_green_next;
    logic [BYTE_W-1:0]   res_blue_reg;
    logic [BYTE_W-1:0]   res_blue_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [BYTE_W-1:0]   read_data_reg;
    logic [BYTE_W-1:0]   red_reg;
    logic [BYTE_W-1:0]   green_reg;
    logic [BYTE_W-1:0]   blue_reg;
    logic                out_load;

    logic                accept;
    logic                clearing;
    logic [ROW_W-1:0]    row;
    logic [1:0]          plane;
    store_ctl_t          store_ctl;
    pal_ctl_t            pal_ctl;
    logic [ROW_DATA_W-1:0] row_rd;
    logic [ROW_DATA_W-1:0] row_wr;
    logic [BYTE_W-1:0]   byte_rd;
    logic [ENTRY_W-1:0]  entry;
    logic [PLANES-1:0]   plane_sel;
    logic [BYTE_W-1:0]   old_byte;

    // Input is taken only in idle and never during the store clearing pass.
    assign in_stall = (state_reg != ST_IDLE) || clearing;
    assign accept   = in_valid && !in_stall;
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);

    pvp_addr_div #(
        .PLANE_BYTES (PLANE_BYTES)
    ) u_addr_div (
        .clk    (clk),
        .start  (accept),
        .offset (offset),
        .row    (row),
        .plane  (plane)
    );

    pvp_plane_store #(
        .PLANE_BYTES (PLANE_BYTES)
    ) u_plane_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (store_ctl),
        .row      (row),
        .wdata    (row_wr),
        .rdata    (row_rd),
        .clearing (clearing)
    );

    pvp_palette #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_palette (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (pal_ctl),
        .data_byte (data_reg[BYTE_W-1:0]),
        .pix       (byte_rd),
        .entry     (entry)
    );

    // The stored byte of the addressed plane, for reads and pixel fetches.
    assign byte_rd = row_rd[{plane, 3'b000} +: BYTE_W];

    // Plane select bits; an upper-lane-only write folds its high byte down.
    assign plane_sel = data_reg[PLANES-1:0] |
                       (upper_reg ? data_reg[BYTE_W +: PLANES] : '0);

    // Masked write of all four planes at one offset. Plane 0 takes the top
    // select bit, plane 3 the bottom one.
    always_comb
    begin
        row_wr   = '0;
        old_byte = '0;
        for (int p = 0; p < PLANES; p++)
        begin
            old_byte = row_rd[p * BYTE_W +: BYTE_W];
            row_wr[p * BYTE_W +: BYTE_W] = (old_byte & ~mask_reg) |
                (plane_sel[PLANES - 1 - p] ? (value_reg & mask_reg) : '0);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        mask_next      = mask_reg;
        value_next     = value_reg;
        res_read_next  = res_read_reg;
        res_red_next   = res_red_reg;
        res_green_next = res_green_reg;
        res_blue_next  = res_blue_reg;
        store_ctl      = '0;
        pal_ctl        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                state_next = ST_RD;
            end
            ST_RD:
            begin
                store_ctl.rd_en = 1'b1;
                state_next      = ST_MOD;
            end
            ST_MOD:
            begin
                res_read_next  = '0;
                res_red_next   = '0;
                res_green_next = '0;
                res_blue_next  = '0;
                state_next     = ST_OUT;
                unique case (func_t'(func_reg))
                    FN_PLANE_WR:  store_ctl.wr_en = 1'b1;
                    FN_BYTE_RD:   res_read_next = byte_rd;
                    FN_MASK_WR:   mask_next = data_reg[BYTE_W-1:0];
                    FN_VALUE_WR:  value_next = data_reg[BYTE_W-1:0];
                    FN_PAL_IDX:   pal_ctl.idx_wr = 1'b1;
                    FN_PAL_COMP:  pal_ctl.comp_wr = 1'b1;
                    FN_PIX_FETCH:
                    begin
                        pal_ctl.rd_en = 1'b1;
                        state_next    = ST_PAL;
                    end
                    default:
                    begin
                        state_next = ST_OUT;
                    end
                endcase
            end
            ST_PAL:
            begin
                res_red_next   = {entry[2*COMP_W +: COMP_W], 2'b00};
                res_green_next = {entry[COMP_W +: COMP_W], 2'b00};
                res_blue_next  = {entry[0 +: COMP_W], 2'b00};
                state_next     = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mask_reg      <= '0;
            value_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mask_reg      <= mask_next;
            value_reg     <= value_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= func;
            data_reg  <= data;
            upper_reg <= upper_lane_only;
        end
        res_read_reg  <= res_read_next;
        res_red_reg   <= res_red_next;
        res_green_reg <= res_green_next;
        res_blue_reg  <= res_blue_next;
        if (out_load)
        begin
            read_data_reg <= res_read_reg;
            red_reg       <= res_red_reg;
            green_reg     <= res_green_reg;
            blue_reg      <= res_blue_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> in_stall)
        else $error("word accepted during store clearing pass");

    a_accept_starts_division: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_DIV))
        else $error("accepted word did not enter division");

    a_store_write_only_plane: assert property (@(posedge clk) disable iff (!rst_n)
        store_ctl.wr_en |-> (state_reg == ST_MOD) && (func_reg == FN_PLANE_WR))
        else $error("store written outside a plane write");

    a_fetch_reads_palette: assert property (@(posedge clk) disable iff (!rst_n)
        pal_ctl.rd_en |=> (state_reg == ST_PAL))
        else $error("palette read not followed by color stage");

    a_out_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg && (state_reg == ST_IDLE))
        else $error("output load lost");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for planar_vram_palette_unit: masked plane writes,
// byte reads, palette loading and pixel fetches against a local predictor.
// Depends on pvp_pkg and the planar_vram_palette_unit RTL only.
module tb_top;

    import pvp_pkg::*;

    // Store geometry as the block is built here (default parameters).
    localparam int          PLANE_SIZE   = PLANE_BYTES_DEF;
    localparam int          LUT_SIZE     = PALETTE_ENTRIES_DEF;
    localparam int          STORE_SIZE   = PLANES * PLANE_SIZE;
    // Code 7 has no member in func_t; it must change nothing.
    localparam logic [2:0]  FN_UNUSED    = 3'd7;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 40;
    localparam int          RESET_CYCLES = 10;
    localparam int          SHOW_LIMIT   = 10;
    // Covers the clearing pass plus about 680 words with worst gaps and
    // stalls, with a wide margin.
    localparam longint      LIMIT_NS     = 64'd20_000_000;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [OFF_W-1:0]  offset;
        logic [DATA_W-1:0] data;
        logic              upper;
    } access_t;

    typedef struct packed {
        logic [BYTE_W-1:0] read_data;
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
    } pix_result_t;

    typedef struct packed {
        access_t     acc;
        logic        fixed_exp;
        pix_result_t want;
    } stim_row_t;

    localparam pix_result_t NO_PIXEL = '0;

    // Directed words. Rows with fixed_exp set carry a result that is obvious
    // from the access itself: reads of a freshly cleared store, register
    // writes and the unused code all return zero. The rest are predicted.
    localparam int NUM_DIRECTED = 25;
    localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
        // Cleared store: lowest and highest address, fetch of entry zero.
        '{'{FN_BYTE_RD,   18'h00000, 16'h0000, 1'b0}, 1'b1, NO_PIXEL},
        '{'{FN_BYTE_RD,   18'h3FFFF, 16'hFFFF, 1'b1}, 1'b1, NO_PIXEL},
        '{'{FN_PIX_FETCH, 18'h20000, 16'h0000, 1'b0}, 1'b1, NO_PIXEL},
        // The unused code with every bit set elsewhere.
        '{'{FN_UNUSED,    18'h3FFFF, 16'hFFFF, 1'b1}, 1'b1, NO_PIXEL},
        // Full mask, value with junk in the high byte.
        '{'{FN_MASK_WR,   18'h00000, 16'hFFFF, 1'b0}, 1'b1, NO_PIXEL},
        '{'{FN_VALUE_WR,  18'h00000, 16'h5AA5, 1'b0}, 1'b1, NO_PIXEL},
        // Plane offset past the end of a plane wraps; planes 0 and 2 get
        // the value, planes 1 and 3 are cleared under the mask.
        '{'{FN_PLANE_WR,  18'h3FFFF, 16'h000A, 1'b0}, 1'b0, NO_PIXEL},
        '{'{FN_BYTE_RD,   18'h0FFFF, 16'h0000, 1'b0}, 1'b0, NO_PIXEL},
        '{'{FN_BYTE_RD,   18'h1FFFF, 16'h0000, 1'b0}, 1'b0, NO_PIXEL},
        // Upper lane only: plane bits come down from the high byte.
        '{'{FN_PLANE_WR,  18'h00010, 16'h0500, 1'b1}, 1'b0, NO_PIXEL},
        '{'{FN_BYTE_RD,   18'h30010, 16'h0000, 1'b0}, 1'b0, NO_PIXEL},
        // Load entry 255, then let the index wrap and load entry 0.
        '{'{FN_PAL_IDX,   18'h00000, 16'hFFFF, 1'b0}, 1'b1, NO_PIXEL},
        '{'{FN_PAL_COMP,  18'h00000, 16'h003F, 1'b0}, 1'b0, NO_PIXEL},
        '{'{FN_PAL_COMP,  18'h00000, 16'hFFC0, 1'b0}, 1'b0, NO_PIXEL},
        '{'{FN_PAL_COMP,  18'h00000, 16'h002A, 1'b0}, 1'b0, NO_PIXEL},
        '{'{FN_PAL_COMP,  18'h00000, 16'h0015, 1'b0}, 1'b0, NO_PIXEL},
        '{'{FN_PAL_COMP,  18'h00000, 16'hFFFF, 1'b0}, 1'b0, NO_PIXEL},
        '{'{FN_PAL_COMP,  18'h00000, 16'h0001, 1'b0}, 1'b0, NO_PIXEL},
        // Store 0xFF in all planes at offset 5, then fetch both entries.
        '{'{FN_VALUE_WR,  18'h00000, 16'h00FF, 1'b0}, 1'b1, NO_PIXEL},
        '{'{FN_PLANE_WR,  18'h00005, 16'h000F, 1'b0}, 1'b0, NO_PIXEL},
        '{'{FN_PIX_FETCH, 18'h30005, 16'h0000, 1'b0}, 1'b0, NO_PIXEL},
        '{'{FN_PIX_FETCH, 18'h00000, 16'h0000, 1'b0}, 1'b0, NO_PIXEL},
        // Partial mask with no plane selected clears only the masked bits.
        '{'{FN_MASK_WR,   18'h00000, 16'h000F, 1'b0}, 1'b1, NO_PIXEL},
        '{'{FN_PLANE_WR,  18'h0FFFF, 16'h0000, 1'b0}, 1'b0, NO_PIXEL},
        '{'{FN_BYTE_RD,   18'h0FFFF, 16'h0000, 1'b0}, 1'b0, NO_PIXEL}
    };

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [FUNC_W-1:0]   func = '0;
    logic [OFF_W-1:0]    offset = '0;
    logic [DATA_W-1:0]   data = '0;
    logic                upper_lane_only = 1'b0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [BYTE_W-1:0]   read_data;
    logic [BYTE_W-1:0]   red;
    logic [BYTE_W-1:0]   green;
    logic [BYTE_W-1:0]   blue;

    // Predictor state: a private copy of the store, registers and palette.
    bit [BYTE_W-1:0]     video_bytes [0:STORE_SIZE-1];
    bit [BYTE_W-1:0]     plane_mask;
    bit [BYTE_W-1:0]     plane_value;
    bit [ENTRY_W-1:0]    color_lut [0:LUT_SIZE-1];
    bit [BYTE_W-1:0]     lut_index;
    bit [1:0]            comp_count;
    bit [COMP_W-1:0]     comp_stage [0:1];

    // Results still owed by the block, oldest first.
    pix_result_t         expected_pixels [$];

    int                  send_idle_pct = 0;
    int                  stall_pct = 0;
    bit                  hold_off = 1'b0;
    int                  fail_count = 0;
    int                  shown_count = 0;

    planar_vram_palette_unit uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .func            (func),
        .offset          (offset),
        .data            (data),
        .upper_lane_only (upper_lane_only),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .read_data       (read_data),
        .red             (red),
        .green           (green),
        .blue            (blue)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Hard limit on the run, independent of any handshake.
    initial
    begin
        #(LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    // Applies one accepted word to the predictor state and returns the
    // result the block owes for it.
    function automatic pix_result_t predict_access(input access_t acc);
        pix_result_t      res;
        int unsigned      base;
        int unsigned      addr;
        logic [15:0]      planes_sel;
        logic [7:0]       kept;
        logic [7:0]       pix;
        logic [17:0]      entry;
        res = '0;
        case (acc.func)
            FN_PLANE_WR:
            begin
                base = acc.offset % PLANE_SIZE;
                planes_sel = acc.data;
                // Upper lane only: fold the high byte onto the low one.
                if (acc.upper)
                    planes_sel = planes_sel | (planes_sel >> 8);
                for (int p = 0; p < PLANES; p++)
                begin
                    addr = base + p * PLANE_SIZE;
                    kept = video_bytes[addr] & ~plane_mask;
                    // Bit 3 selects plane 0, bit 0 selects plane 3.
                    if (planes_sel[3 - p])
                        kept = kept | (plane_value & plane_mask);
                    video_bytes[addr] = kept;
                end
            end
            FN_BYTE_RD:
                res.read_data = video_bytes[acc.offset % STORE_SIZE];
            FN_MASK_WR:
                plane_mask = acc.data[7:0];
            FN_VALUE_WR:
                plane_value = acc.data[7:0];
            FN_PAL_IDX:
                lut_index = acc.data[7:0];
            FN_PAL_COMP:
            begin
                if (comp_count < 2)
                begin
                    comp_stage[comp_count[0]] = acc.data[5:0];
                    comp_count = comp_count + 1'b1;
                end
                else
                begin
                    // Third component commits the entry; the index wraps.
                    color_lut[lut_index % LUT_SIZE] =
                        {comp_stage[0], comp_stage[1], acc.data[5:0]};
                    lut_index = lut_index + 1'b1;
                    comp_count = '0;
                end
            end
            FN_PIX_FETCH:
            begin
                pix = video_bytes[acc.offset % STORE_SIZE];
                entry = color_lut[pix % LUT_SIZE];
                res.red   = {entry[17:12], 2'b00};
                res.green = {entry[11:6], 2'b00};
                res.blue  = {entry[5:0], 2'b00};
            end
            default:
                res = '0;
        endcase
        return res;
    endfunction

    // Most addresses fall in a small window at both ends of each plane so
    // that reads and fetches land on bytes that writes have touched.
    function automatic logic [OFF_W-1:0] pick_offset();
        logic [15:0] low;
        if ($urandom_range(99) < 15)
            return 18'($urandom());
        if ($urandom_range(1) == 1)
            low = 16'($urandom_range(15));
        else
            low = 16'hFFF0 | 16'($urandom_range(15));
        return {2'($urandom_range(3)), low};
    endfunction

    function automatic access_t build_access(input logic [FUNC_W-1:0] fn);
        access_t acc;
        acc.func   = fn;
        acc.offset = pick_offset();
        acc.data   = 16'($urandom());
        acc.upper  = ($urandom_range(3) == 0);
        case (fn)
            FN_MASK_WR:
                if ($urandom_range(1) == 1)
                    acc.data[7:0] = 8'hFF;
            // Keep values and palette indexes often small, so that stored
            // bytes point at palette entries that have been loaded.
            FN_VALUE_WR, FN_PAL_IDX:
                if ($urandom_range(1) == 1)
                    acc.data[7:0] = 8'($urandom_range(15));
            default:
                acc.data = acc.data;
        endcase
        return acc;
    endfunction

    // Offers one word, waits for it to be taken, then records what the
    // block owes for it. The valid is lowered only for a real idle cycle.
    task automatic offer_word(input access_t acc, input bit use_fixed,
                              input pix_result_t fixed);
        pix_result_t owed;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        func            <= acc.func;
        offset          <= acc.offset;
        data            <= acc.data;
        upper_lane_only <= acc.upper;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        owed = predict_access(acc);
        if (use_fixed)
            owed = fixed;
        expected_pixels.push_back(owed);
    endtask

    // Random traffic. Palette loads go out as index-plus-three-component
    // bursts so that entries really get committed; now and then a burst is
    // cut short or runs long to leave the component count mid-way.
    task automatic run_random(input int quota);
        int sent;
        int pick;
        int comps;
        sent = 0;
        while (sent < quota)
        begin
            pick = $urandom_range(99);
            if (pick < 14)
            begin
                offer_word(build_access(FN_PAL_IDX), 1'b0, NO_PIXEL);
                comps = ($urandom_range(9) == 0) ? $urandom_range(1, 5) : 3;
                repeat (comps)
                    offer_word(build_access(FN_PAL_COMP), 1'b0, NO_PIXEL);
                sent += comps + 1;
            end
            else
            begin
                if (pick < 40)
                    offer_word(build_access(FN_PLANE_WR), 1'b0, NO_PIXEL);
                else if (pick < 58)
                    offer_word(build_access(FN_BYTE_RD), 1'b0, NO_PIXEL);
                else if (pick < 64)
                    offer_word(build_access(FN_MASK_WR), 1'b0, NO_PIXEL);
                else if (pick < 70)
                    offer_word(build_access(FN_VALUE_WR), 1'b0, NO_PIXEL);
                else if (pick < 96)
                    offer_word(build_access(FN_PIX_FETCH), 1'b0, NO_PIXEL);
                else
                    offer_word(build_access(FN_UNUSED), 1'b0, NO_PIXEL);
                sent += 1;
            end
        end
    endtask

    // Result side: every word taken from the output is matched against the
    // oldest owed result, then the stall for the next cycle is chosen. The
    // long hold-off forces the block to fill and stall its input.
    always @(posedge clk)
    begin
        pix_result_t got;
        pix_result_t owed;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{read_data, red, green, blue};
            if (expected_pixels.size() == 0)
            begin
                if (shown_count < SHOW_LIMIT)
                    $display("Unexpected result word: rd=%h r=%h g=%h b=%h",
                             got.read_data, got.red, got.green, got.blue);
                shown_count++;
                fail_count++;
            end
            else
            begin
                owed = expected_pixels.pop_front();
                if (got.read_data !== owed.read_data || got.red !== owed.red ||
                    got.green !== owed.green || got.blue !== owed.blue)
                begin
                    // Fields are listed as read_data, red, green, blue.
                    if (shown_count < SHOW_LIMIT)
                        $display("Mismatch at %0t: expected %h %h %h %h, got %h %h %h %h",
                                 $realtime, owed.read_data, owed.red, owed.green,
                                 owed.blue, got.read_data, got.red, got.green,
                                 got.blue);
                    shown_count++;
                    fail_count++;
                end
            end
        end
        out_stall <= hold_off || ($urandom_range(99) < stall_pct);
    end

    initial
    begin
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed words go in with no idling. The first one waits out the
        // clearing pass behind in_stall.
        for (int r = 0; r < NUM_DIRECTED; r++)
            offer_word(DIRECTED[r].acc, DIRECTED[r].fixed_exp, DIRECTED[r].want);

        // Free-running traffic on both sides.
        send_idle_pct = 0;
        stall_pct    <= 0;
        run_random(130);

        // Sparse sender.
        send_idle_pct = 81;
        run_random(130);

        // Receiver mostly stalling.
        send_idle_pct = 0;
        stall_pct    <= 81;
        run_random(130);

        // Both sides idling part of the time.
        send_idle_pct = 37;
        stall_pct    <= 37;
        run_random(130);

        // Receiver holds off for a long stretch while the sender keeps
        // pushing; the block backs up into its input.
        send_idle_pct = 0;
        stall_pct    <= 0;
        fork
            begin
                hold_off <= 1'b1;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
                hold_off <= 1'b0;
            end
        join_none
        run_random(130);

        in_valid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        // Any extra word from the block shows up in this window.
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
